[sv/bc1_block_encoder_unit_defines.svh]
// Assertion macros shared by the BC1 block encoder RTL.
// Bodies refer to aclk and aresetn of the including module.
`ifndef BC1_BLOCK_ENCODER_UNIT_DEFINES_SVH
`define BC1_BLOCK_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BC1E_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BC1E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bc1e_pkg.sv]
// Shared types, constants and color helpers for the BC1 block encoder.
// No dependencies.
`default_nettype none

package bc1e_pkg;

    localparam int TEXELS              = 16;
    localparam int MAX_IMAGE_SIZE_DEF  = 16384;
    localparam int CFG_W               = 15;
    localparam int CFG_IDX_W           = 1;
    localparam int RESET_SIZE          = 256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // position report from the tile tracker
    typedef struct packed {
        logic [3:0] pos;        // texel slot in the tile
        logic       black;      // texel lies outside the image
        logic       last_tile;  // current tile is the final one
    } pos_info_t;

    // strobes from the sequencer to the index unit
    typedef struct packed {
        logic pal_load;  // latch endpoints and build palette
        logic tex_vld;   // texel store read data is valid
    } idx_ctrl_t;

    function automatic logic [15:0] pack565(input rgb_t c);
        return {c.red[7:3], c.green[7:2], c.blue[7:3]};
    endfunction

    // bit-replicating unpack
    function automatic rgb_t unpack565(input logic [15:0] c);
        rgb_t u;
        u.red   = {c[15:11], c[15:13]};
        u.green = {c[10:5],  c[10:9]};
        u.blue  = {c[4:0],   c[4:2]};
        return u;
    endfunction

    // floor(x/3) for x < 768 via reciprocal 683/2048
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = x * 10'd683;
        return p[18:11];
    endfunction

endpackage

`default_nettype wire

[sv/bc1e_texel_mem.sv]
// Sixteen-entry texel store, one write and one registered read port.
// Uses bc1e_pkg.
`default_nettype none

module bc1e_texel_mem (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [3:0]    waddr,
    input  wire bc1e_pkg::rgb_t wdata,
    input  wire logic          re,
    input  wire logic [3:0]    raddr,
    output bc1e_pkg::rgb_t     rdata
);

    bc1e_pkg::rgb_t mem [bc1e_pkg::TEXELS];
    bc1e_pkg::rgb_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/bc1e_tile_pos.sv]
// Size registers, texel/tile position tracking, edge blackening and last-tile flag.
// Uses bc1e_pkg.
`default_nettype none

module bc1e_tile_pos #(
    parameter int MAX_IMAGE_SIZE = bc1e_pkg::MAX_IMAGE_SIZE_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [bc1e_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bc1e_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           accept,
    output bc1e_pkg::pos_info_t                 info
);

    localparam int SIZE_W = $clog2(MAX_IMAGE_SIZE + 1);
    localparam int CW     = ((SIZE_W > bc1e_pkg::CFG_W) ? SIZE_W : bc1e_pkg::CFG_W) + 2;
    localparam int TILES  = (MAX_IMAGE_SIZE + 3) / 4;
    localparam int TILE_W = (TILES > 1) ? $clog2(TILES) : 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_IMAGE_SIZE);

    logic [bc1e_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [3:0]                 pos_reg, pos_next;
    logic [TILE_W-1:0]          col_reg, col_next, row_reg, row_next;

    logic [CW-1:0] w_eff, h_eff, cols, rows, x, y;
    logic          last_col, last_row;

    function automatic logic [CW-1:0] clamp(input logic [bc1e_pkg::CFG_W-1:0] v);
        logic [CW-1:0] e;
        e = CW'(v);
        if (e == '0) begin
            return CW'(1);
        end
        if (e > MAX_C) begin
            return MAX_C;
        end
        return e;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bc1e_pkg::CFG_W'(bc1e_pkg::RESET_SIZE);
            height_reg <= bc1e_pkg::CFG_W'(bc1e_pkg::RESET_SIZE);
        end else if (cfg_we) begin
            case (cfg_index)
                bc1e_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                bc1e_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff    = clamp(width_reg);
        h_eff    = clamp(height_reg);
        cols     = (w_eff + CW'(3)) >> 2;
        rows     = (h_eff + CW'(3)) >> 2;
        x        = CW'({col_reg, pos_reg[1:0]});
        y        = CW'({row_reg, pos_reg[3:2]});
        last_col = (CW'(col_reg) + CW'(1)) >= cols;
        last_row = (CW'(row_reg) + CW'(1)) >= rows;

        pos_next = pos_reg + 4'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (pos_reg == 4'(bc1e_pkg::TEXELS - 1)) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + TILE_W'(1);
            end else begin
                col_next = col_reg + TILE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign info.pos       = pos_reg;
    assign info.black     = (x >= w_eff) || (y >= h_eff);
    assign info.last_tile = last_col && last_row;

endmodule

`default_nettype wire

[sv/bc1e_index_unit.sv]
// Endpoint packing, palette build and per-texel nearest-color search.
// Two stages: squared channel differences, then sum and first-minimum pick.
// Uses bc1e_pkg.
`default_nettype none

module bc1e_index_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bc1e_pkg::idx_ctrl_t ctrl,
    input  wire bc1e_pkg::rgb_t      min_rgb,
    input  wire bc1e_pkg::rgb_t      max_rgb,
    input  wire bc1e_pkg::rgb_t      texel,
    output logic [15:0]              endpoint_low,
    output logic [15:0]              endpoint_high,
    output logic [31:0]              index_bits
);

    localparam int NPAL = 4;

    logic [15:0]    ep_lo_reg, ep_hi_reg;
    bc1e_pkg::rgb_t pal_reg [NPAL];
    logic [15:0]    sq_reg  [NPAL][3];
    logic           sq_vld_reg;
    logic [31:0]    bits_reg;

    bc1e_pkg::rgb_t u_lo, u_hi, pal2, pal3;
    logic [15:0]    lo_c, hi_c;
    logic [17:0]    pal_dist [NPAL];
    logic [17:0]    best_d;
    logic [1:0]     best;

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // palette from packed endpoints
    always_comb begin
        lo_c       = bc1e_pkg::pack565(min_rgb);
        hi_c       = bc1e_pkg::pack565(max_rgb);
        u_lo       = bc1e_pkg::unpack565(lo_c);
        u_hi       = bc1e_pkg::unpack565(hi_c);
        pal2.red   = bc1e_pkg::div3({1'b0, u_lo.red, 1'b0} + 10'(u_hi.red));
        pal2.green = bc1e_pkg::div3({1'b0, u_lo.green, 1'b0} + 10'(u_hi.green));
        pal2.blue  = bc1e_pkg::div3({1'b0, u_lo.blue, 1'b0} + 10'(u_hi.blue));
        pal3.red   = bc1e_pkg::div3(10'(u_lo.red) + {1'b0, u_hi.red, 1'b0});
        pal3.green = bc1e_pkg::div3(10'(u_lo.green) + {1'b0, u_hi.green, 1'b0});
        pal3.blue  = bc1e_pkg::div3(10'(u_lo.blue) + {1'b0, u_hi.blue, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.pal_load) begin
            ep_lo_reg  <= lo_c;
            ep_hi_reg  <= hi_c;
            pal_reg[0] <= u_lo;
            pal_reg[1] <= u_hi;
            pal_reg[2] <= pal2;
            pal_reg[3] <= pal3;
        end
    end

    // stage 1: squared differences
    always_ff @(posedge aclk) begin
        if (ctrl.tex_vld) begin
            for (int p = 0; p < NPAL; p++) begin
                sq_reg[p][0] <= 16'(absdiff(texel.red,   pal_reg[p].red))
                              * 16'(absdiff(texel.red,   pal_reg[p].red));
                sq_reg[p][1] <= 16'(absdiff(texel.green, pal_reg[p].green))
                              * 16'(absdiff(texel.green, pal_reg[p].green));
                sq_reg[p][2] <= 16'(absdiff(texel.blue,  pal_reg[p].blue))
                              * 16'(absdiff(texel.blue,  pal_reg[p].blue));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else begin
            sq_vld_reg <= ctrl.tex_vld;
        end
    end

    // stage 2: sum, keep first minimum
    always_comb begin
        for (int p = 0; p < NPAL; p++) begin
            pal_dist[p] = 18'(sq_reg[p][0]) + 18'(sq_reg[p][1]) + 18'(sq_reg[p][2]);
        end
        best   = 2'd0;
        best_d = pal_dist[0];
        for (int p = 1; p < NPAL; p++) begin
            if (pal_dist[p] < best_d) begin
                best_d = pal_dist[p];
                best   = 2'(p);
            end
        end
    end

    // texel 0 ends up in the low bits after sixteen shifts
    always_ff @(posedge aclk) begin
        if (sq_vld_reg) begin
            bits_reg <= {best, bits_reg[31:2]};
        end
    end

    assign endpoint_low  = ep_lo_reg;
    assign endpoint_high = ep_hi_reg;
    assign index_bits    = bits_reg;

endmodule

`default_nettype wire

[sv/bc1_block_encoder_unit.sv]
// BC1 block encoder top level: sequencer, running extremes and result register.
// Uses bc1e_pkg, bc1e_tile_pos, bc1e_texel_mem, bc1e_index_unit and the
// assertion macros in bc1_block_encoder_unit_defines.svh.
//
// Usage:
//   s_ channel: one texel per transfer (red, green, blue), sixteen per 4x4 tile
//   in row order, tiles left to right then top to bottom. Texels outside the
//   configured image are replaced by black but still fill their tile slot.
//   m_ channel: one transfer per tile carrying both RGB565 endpoints and the
//   32 index bits; tlast marks the final tile of the image.
//   Config: cfg_we/cfg_index/cfg_wdata write image_width (0) or image_height (1);
//   write only while the block is idle.
// Timing:
//   Texels load at one per cycle into a 16-entry texel store while the block
//   is in its load state. After the sixteenth transfer come a palette step, an
//   index scan (16 store reads plus a two-stage distance pipeline) and a move
//   of the result into the output register, which raises m_tvalid. No texels
//   are taken during the palette, scan and result steps; the next tile loads
//   once the result has entered the output register.
// Reset: aresetn (synchronous, low) empties the output, clears extremes and
//   returns to tile 0 with 256x256 size.
// Stall: the result waits in the output register; the next tile loads
//   meanwhile and its own result waits for that register to drain.
`include "bc1_block_encoder_unit_defines.svh"
`default_nettype none

module bc1_block_encoder_unit #(
    parameter int MAX_IMAGE_SIZE = bc1e_pkg::MAX_IMAGE_SIZE_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [bc1e_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bc1e_pkg::CFG_W-1:0]     cfg_wdata,
    // texel input
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,  // red, green, blue
    // tile result
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [63:0]                         m_tdata,  // endpoint_low, endpoint_high, index_bits
    output logic                                m_tlast   // last tile of the image
);

    localparam int          CNT_W     = $clog2(bc1e_pkg::TEXELS + 2);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(bc1e_pkg::TEXELS + 1);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_PAL  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      scan_cnt_reg;
    logic                  mem_vld_reg;
    bc1e_pkg::rgb_t        min_reg, max_reg;
    logic                  last_reg;
    logic                  m_tvalid_reg;
    logic [63:0]           m_tdata_reg;
    logic                  m_tlast_reg;

    logic                  s_accept;
    logic                  tile_end;
    logic                  rd_en;
    logic                  out_load;
    bc1e_pkg::pos_info_t   pos_info;
    bc1e_pkg::rgb_t        texel_in, texel_rd;
    bc1e_pkg::idx_ctrl_t   idx_ctrl;
    logic [15:0]           ep_lo, ep_hi;
    logic [31:0]           idx_bits;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign tile_end = s_accept && (pos_info.pos == 4'(bc1e_pkg::TEXELS - 1));

    // outside-image texels become black
    assign texel_in.red   = pos_info.black ? 8'd0 : s_tdata[7:0];
    assign texel_in.green = pos_info.black ? 8'd0 : s_tdata[15:8];
    assign texel_in.blue  = pos_info.black ? 8'd0 : s_tdata[23:16];

    bc1e_tile_pos #(
        .MAX_IMAGE_SIZE(MAX_IMAGE_SIZE)
    ) u_tile_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (s_accept),
        .info      (pos_info)
    );

    // scan reads one store entry per cycle until all sixteen entries are read
    assign rd_en = (state_reg == ST_SCAN) && (scan_cnt_reg < CNT_W'(bc1e_pkg::TEXELS));

    bc1e_texel_mem u_texel_mem (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (pos_info.pos),
        .wdata (texel_in),
        .re    (rd_en),
        .raddr (scan_cnt_reg[3:0]),
        .rdata (texel_rd)
    );

    assign idx_ctrl.pal_load = (state_reg == ST_PAL);
    assign idx_ctrl.tex_vld  = mem_vld_reg;

    bc1e_index_unit u_index_unit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (idx_ctrl),
        .min_rgb       (min_reg),
        .max_rgb       (max_reg),
        .texel         (texel_rd),
        .endpoint_low  (ep_lo),
        .endpoint_high (ep_hi),
        .index_bits    (idx_bits)
    );

    // result register takes the tile once it is empty or draining
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (tile_end) state_next = ST_PAL;
            ST_PAL:  state_next = ST_SCAN;
            ST_SCAN: if (scan_cnt_reg == SCAN_LAST) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            scan_cnt_reg <= '0;
            mem_vld_reg  <= 1'b0;
            last_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mem_vld_reg <= rd_en;
            if (state_reg == ST_PAL) begin
                scan_cnt_reg <= '0;
            end else if (state_reg == ST_SCAN) begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (tile_end) begin
                last_reg <= pos_info.last_tile;
            end
        end
    end

    // running extremes; cleared once the palette has latched them
    always_ff @(posedge aclk) begin
        if (!aresetn || state_reg == ST_PAL) begin
            min_reg <= '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
            max_reg <= '0;
        end else if (s_accept) begin
            if (texel_in.red   < min_reg.red)   min_reg.red   <= texel_in.red;
            if (texel_in.green < min_reg.green) min_reg.green <= texel_in.green;
            if (texel_in.blue  < min_reg.blue)  min_reg.blue  <= texel_in.blue;
            if (texel_in.red   > max_reg.red)   max_reg.red   <= texel_in.red;
            if (texel_in.green > max_reg.green) max_reg.green <= texel_in.green;
            if (texel_in.blue  > max_reg.blue)  max_reg.blue  <= texel_in.blue;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {idx_bits, ep_hi, ep_lo};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `BC1E_ASSERT_NEXT(a_tile_end_to_pal, tile_end, state_reg == ST_PAL, "tile end did not start palette")
    `BC1E_ASSERT_NEXT(a_scan_to_done, (state_reg == ST_SCAN) && (scan_cnt_reg == SCAN_LAST), state_reg == ST_DONE, "scan overran")
    `BC1E_ASSERT_SAME(a_pipe_drained, state_reg == ST_DONE, !mem_vld_reg && !rd_en, "scan pipeline busy at result")
    `BC1E_ASSERT_NEXT(a_extremes_order, s_accept, (min_reg.red <= max_reg.red) && (min_reg.green <= max_reg.green) && (min_reg.blue <= max_reg.blue), "extremes out of order")

endmodule

`default_nettype wire
